>>> design/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg: shared definitions for the linear interpolation resampler
// Widths, position constants and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package lir_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;
	localparam int STEP_W   = 20;
	localparam int POS_W    = 22;
	localparam int CMP_W    = POS_W + 1;
	localparam int PROD_W   = 2 * (SAMPLE_W + 1);
	localparam int SUM_W    = PROD_W + 1;

	// one input sample in Q(FRAC_W)
	localparam logic [POS_W-1:0]  ONE_POS  = POS_W'(1) << FRAC_W;
	localparam logic [CMP_W-1:0]  FOUR_POS = CMP_W'(1) << (FRAC_W + 2);
	localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(1) << (FRAC_W - 5);
	localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(1) << FRAC_W;
	localparam logic [SUM_W-1:0]  HALF_LSB = SUM_W'(1) << (FRAC_W - 1);

	typedef struct packed {
		logic e_now;    // current position yields a result
		logic e_next;   // position after one more step yields a result
		logic last;     // item being worked on ends the stream
		logic out_free; // output register can take a result this cycle
	} sts_t;

	typedef struct packed {
		logic load;     // input transaction
		logic emit;     // push a sample result
		logic marker;   // push a bare end marker
		logic finish;   // item complete, update carried state
	} cmd_t;

endpackage

>>> design/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler: streaming linear interpolation resampler
// One channel of signed 16-bit samples resampled by a Q4.16 phase step.
//
//   channel  dir  tdata          tlast      tuser
//   s_*      in   in_sample      in_last    -
//   m_*      out  out_sample     run_last   {stream_end, has_sample}
//   cfg_*    in   phase_step     -          -
//
// An item is accepted, then the single interpolator issues one result a cycle
// for it while m_tready does not stall; an item that causes no result is still
// closed in a step of its own. s_tready is low until the item is done.
// m_tready low stalls the sequencer; the output register holds one result.
// Reset (arst_n low) clears the stream state and sets phase_step to 1.0.
// ----------------------------------------------------------------------------
module linear_interp_resampler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [lir_pkg::STEP_W-1:0]         cfg_wr_data, // phase_step
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lir_pkg::SAMPLE_W-1:0]       s_tdata,     // in_sample
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lir_pkg::SAMPLE_W-1:0]       m_tdata,     // out_sample
	output logic                               m_tlast,
	output logic [1:0]                         m_tuser      // {stream_end, has_sample}
);

	lir_pkg::sts_t sts;
	lir_pkg::cmd_t cmd;
	logic signed [lir_pkg::SAMPLE_W-1:0] out_sample;
	logic has_sample;
	logic stream_end;

	lir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	lir_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_sample   ($signed(s_tdata)),
		.in_last     (s_tlast),
		.cmd         (cmd),
		.m_tready    (m_tready),
		.sts         (sts),
		.m_tvalid    (m_tvalid),
		.out_sample  (out_sample),
		.has_sample  (has_sample),
		.run_last    (m_tlast),
		.stream_end  (stream_end)
	);

	assign m_tdata = out_sample;
	assign m_tuser = {stream_end, has_sample};

endmodule

>>> design/lir_ctrl.sv
// ----------------------------------------------------------------------------
// lir_ctrl: resampler sequencer
// Takes one item, then steps the datapath once per result (once if none) until done.
// ----------------------------------------------------------------------------
module lir_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  lir_pkg::sts_t  sts,
	output logic           s_tready,
	output lir_pkg::cmd_t  cmd
);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign s_tready = ready_q;

	always_comb begin
		cmd      = '0;
		cmd.load = s_tvalid && ready_q;
		if (state_q == ST_RUN && sts.out_free) begin
			if (sts.e_now) begin
				cmd.emit   = 1'b1;
				cmd.finish = !sts.e_next;
			end else begin
				// nothing (more) to give; final item with no result gets a marker
				cmd.marker = sts.last;
				cmd.finish = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
						ready_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

>>> design/lir_dpath.sv
// ----------------------------------------------------------------------------
// lir_dpath: resampler datapath
// Position accumulator, interpolator (one multiply) and output register.
// ----------------------------------------------------------------------------
module lir_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lir_pkg::STEP_W-1:0]        cfg_wr_data,
	input  logic signed [lir_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                              in_last,
	input  lir_pkg::cmd_t                     cmd,
	input  logic                              m_tready,
	output lir_pkg::sts_t                     sts,
	output logic                              m_tvalid,
	output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample,
	output logic                              has_sample,
	output logic                              run_last,
	output logic                              stream_end
);

	logic [lir_pkg::STEP_W-1:0]          step_q;
	// position of next output relative to prev_q; ONE_POS when no sample is held
	logic [lir_pkg::POS_W-1:0]           pos_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] prev_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] cur_q;
	logic                                last_q;
	logic                                out_valid_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                                out_has_q;
	logic                                out_run_last_q;
	logic                                out_end_q;

	logic [lir_pkg::POS_W-1:0]           pos_next;
	logic signed [lir_pkg::SAMPLE_W:0]   diff;
	logic signed [lir_pkg::SAMPLE_W:0]   frac;
	logic signed [lir_pkg::PROD_W-1:0]   prod;
	logic signed [lir_pkg::SUM_W-1:0]    acc_sum;
	logic signed [lir_pkg::SAMPLE_W-1:0] interp_val;
	logic signed [lir_pkg::SAMPLE_W-1:0] res_val;

	// final item: results continue while 2*pos + step <= 4.0 (held tail included)
	function automatic logic yields(input logic [lir_pkg::POS_W-1:0] pos,
			input logic [lir_pkg::STEP_W-1:0] step, input logic last);
		logic [lir_pkg::CMP_W-1:0] twice;
		twice = {pos, 1'b0} + lir_pkg::CMP_W'(step);
		if (last)
			yields = (twice <= lir_pkg::FOUR_POS);
		else
			yields = (pos < lir_pkg::ONE_POS);
	endfunction

	assign pos_next = pos_q + lir_pkg::POS_W'(step_q);

	assign diff    = (lir_pkg::SAMPLE_W + 1)'(cur_q) - (lir_pkg::SAMPLE_W + 1)'(prev_q);
	assign frac    = $signed({1'b0, pos_q[lir_pkg::FRAC_W-1:0]});
	assign prod    = diff * frac;
	assign acc_sum = ($signed(lir_pkg::SUM_W'(prev_q)) <<< lir_pkg::FRAC_W)
		+ lir_pkg::SUM_W'(prod) + lir_pkg::HALF_LSB;
	assign interp_val = acc_sum[lir_pkg::FRAC_W +: lir_pkg::SAMPLE_W];
	assign res_val    = (pos_q < lir_pkg::ONE_POS) ? interp_val : cur_q;

	assign sts.e_now    = yields(pos_q, step_q, last_q);
	assign sts.e_next   = yields(pos_next, step_q, last_q);
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || m_tready;

	assign m_tvalid   = out_valid_q;
	assign out_sample = out_sample_q;
	assign has_sample = out_has_q;
	assign run_last   = out_run_last_q;
	assign stream_end = out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= lir_pkg::STEP_RST;
			pos_q       <= lir_pkg::ONE_POS;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				step_q <= (cfg_wr_data < lir_pkg::STEP_MIN) ? lir_pkg::STEP_MIN : cfg_wr_data;

			if (cmd.finish) begin
				if (last_q)
					pos_q <= lir_pkg::ONE_POS;
				else if (cmd.emit)
					pos_q <= pos_next - lir_pkg::ONE_POS;
				else
					pos_q <= pos_q - lir_pkg::ONE_POS;
			end else if (cmd.emit) begin
				pos_q <= pos_next;
			end

			if (cmd.emit || cmd.marker)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q  <= in_sample;
			last_q <= in_last;
		end
		if (cmd.finish && !last_q)
			prev_q <= cur_q;
		if (cmd.emit) begin
			out_sample_q   <= res_val;
			out_has_q      <= 1'b1;
			out_run_last_q <= cmd.finish;
			out_end_q      <= cmd.finish && last_q;
		end else if (cmd.marker) begin
			out_sample_q   <= '0;
			out_has_q      <= 1'b0;
			out_run_last_q <= 1'b1;
			out_end_q      <= 1'b1;
		end
	end

endmodule

>>> design/lir_checker.sv
// ----------------------------------------------------------------------------
// lir_checker: port-level checks for the resampler
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module lir_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [lir_pkg::SAMPLE_W-1:0] m_tdata,
	input logic                         m_tlast,
	input logic [1:0]                   m_tuser
);

	// the end of a stream also closes the run of its item
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("stream_end without tlast");

	// a bare marker carries zero data and ends the stream
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[1] && m_tdata == '0)
		else $error("malformed end marker");

	// one item at a time: input closes after each transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transaction");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
